### design/bic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot image checker package
// Shared constants, types and the byte-wide CRC-32 update for the boot image
// checker and its result channel interface.
// ----------------------------------------------------------------------------
package bic_pkg;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_MAGIC  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_IMAGE_BYTES = CSR_INDEX_W'(1);

   // Reset values of the configuration registers.
   localparam logic [31:0] RESET_MAGIC     = 32'hDEAD_BEEF;
   localparam logic [31:0] RESET_MAX_BYTES = 32'(480 * 1024);

   // Reflected CRC-32 constants.
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // Header layout: four little-endian 32-bit words.
   localparam int HEADER_BYTES = 16;
   localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
   localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);
   localparam int HDR_MAGIC = 0;
   localparam int HDR_SIZE  = 1;
   localparam int HDR_ENTRY = 2;
   localparam int HDR_CRC   = 3;

   // Checker phase, one-hot.
   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_IMAGE  = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   // Verdict codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_MAGIC = 2'd1,
      STATUS_BAD_SIZE  = 2'd2,
      STATUS_BAD_CRC   = 2'd3
   } status_type;

   // One result item.
   typedef struct packed {
      logic        write_valid;
      logic [31:0] write_address;
      logic [7:0]  write_data;
      logic        verdict_valid;
      status_type  status;
      logic [31:0] entry_address;
      logic [31:0] computed_crc;
   } rsp_type;

   // Folds one byte into a reflected CRC-32, one bit per step.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### design/bic_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot image checker request channel
// Valid/ready channel that carries one flash byte and its restart flag.
// ----------------------------------------------------------------------------
interface bic_req_if;
   logic       valid;
   logic       ready;
   logic       first_of_image;
   logic [7:0] data_byte;

   modport source (output valid, output first_of_image, output data_byte, input ready);
   modport sink   (input valid, input first_of_image, input data_byte, output ready);
endinterface

### design/bic_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot image checker result channel
// Valid/ready channel that carries an image store and/or a check verdict.
// ----------------------------------------------------------------------------
interface bic_rsp_if import bic_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [31:0] write_address;
   logic [7:0]  write_data;
   logic        verdict_valid;
   status_type  status;
   logic [31:0] entry_address;
   logic [31:0] computed_crc;

   modport source (output valid, output write_valid, output write_address,
                   output write_data, output verdict_valid, output status,
                   output entry_address, output computed_crc, input ready);
   modport sink   (input valid, input write_valid, input write_address,
                   input write_data, input verdict_valid, input status,
                   input entry_address, input computed_crc, output ready);
endinterface

### design/bic_rsp_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot image checker result skid buffer
// Output register plus one skid entry, so a new request can be taken while a
// finished result still waits on the result channel.
// ----------------------------------------------------------------------------
module bic_rsp_skid import bic_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  rsp_type     push_data,
   output logic        push_ready,
   bic_rsp_if.source   rsp_chan
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   // Room exists as long as the skid entry is empty.
   assign push_ready = !skid_valid_ff;
   assign out_free   = !out_valid_ff || rsp_chan.ready;

   // Refill the output register from the skid entry first to keep order.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push_valid;
            skid_data_in  = push_data;
         end else begin
            out_valid_in  = push_valid;
            out_data_in   = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Drive the result channel from the output register.
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.write_valid   = out_data_ff.write_valid;
   assign rsp_chan.write_address = out_data_ff.write_address;
   assign rsp_chan.write_data    = out_data_ff.write_data;
   assign rsp_chan.verdict_valid = out_data_ff.verdict_valid;
   assign rsp_chan.status        = out_data_ff.status;
   assign rsp_chan.entry_address = out_data_ff.entry_address;
   assign rsp_chan.computed_crc  = out_data_ff.computed_crc;

   // The skid entry only fills behind a held output register.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   // A result is never pushed when there is no room for it.
   assert property (@(posedge clock) disable iff (reset) push_valid |-> push_ready)
      else $error("result pushed into a full skid buffer");

endmodule

### design/boot_image_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot image checker
// Parses a boot image header from a flash byte stream, emits image stores and
// checks the image CRC-32.
// ----------------------------------------------------------------------------
// The block takes one flash byte per clock cycle and stalls only when results
// back up: each request is folded into the header or the byte-wide CRC-32 in
// the cycle it is accepted, and any result is registered. An output register
// with one skid entry sits in front of the result channel, so requests keep
// flowing while one result waits; only a second waiting result drops
// req_chan.ready. The 16 header bytes give no result unless the header is
// rejected; each image byte gives one store, and the last one also carries
// the verdict. After a verdict bytes are dropped until one arrives with
// first_of_image set. Registers may be written only while idle.
// ----------------------------------------------------------------------------
module boot_image_checker_unit import bic_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bic_req_if.sink                req_chan,
   bic_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Control state.
   phase_type   phase_ff, phase_in;
   logic [31:0] byte_count_ff, byte_count_in;
   logic [31:0] running_crc_ff, running_crc_in;
   // Header bytes: word, lane, bit.
   logic [3:0][3:0][7:0] hdr_ff, hdr_in;
   // Configuration registers.
   logic [31:0] magic_cfg_ff;
   logic [31:0] max_bytes_cfg_ff;

   logic        req_accept;
   logic        push_ready;
   logic        result_valid;
   rsp_type     result;
   phase_type   cur_phase;
   logic [31:0] cur_count;
   logic [31:0] cur_crc;
   logic [31:0] crc_step;
   logic [31:0] count_next;
   logic        bad_magic;
   logic        bad_size;

   assign req_chan.ready = push_ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // A restart flag puts the request back at header byte zero.
   assign cur_phase = req_chan.first_of_image ? PH_HEADER : phase_ff;
   assign cur_count = req_chan.first_of_image ? 32'd0 : byte_count_ff;
   assign cur_crc   = req_chan.first_of_image ? ALL_ONES : running_crc_ff;

   assign crc_step   = crc_byte(cur_crc, req_chan.data_byte);
   assign count_next = cur_count + 32'd1;

   // Header checks; magic and size words are complete by the last header byte.
   assign bad_magic = hdr_ff[HDR_MAGIC] != magic_cfg_ff;
   assign bad_size  = (hdr_ff[HDR_SIZE] == 32'd0) || (hdr_ff[HDR_SIZE] > max_bytes_cfg_ff);

   // Per-request processing.
   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      running_crc_in = running_crc_ff;
      hdr_in         = hdr_ff;
      result         = '0;
      result_valid   = 1'b0;
      if (req_accept) begin
         phase_in       = cur_phase;
         byte_count_in  = cur_count;
         running_crc_in = cur_crc;
         unique case (cur_phase)
            PH_HEADER: begin
               hdr_in[cur_count[3:2]][cur_count[1:0]] = req_chan.data_byte;
               if (cur_count[HDR_CNT_W-1:0] == HDR_LAST) begin
                  byte_count_in = 32'd0;
                  if (bad_magic || bad_size) begin
                     phase_in             = PH_DONE;
                     result_valid         = 1'b1;
                     result.verdict_valid = 1'b1;
                     result.status        = bad_magic ? STATUS_BAD_MAGIC : STATUS_BAD_SIZE;
                     result.entry_address = hdr_ff[HDR_ENTRY];
                  end else begin
                     phase_in = PH_IMAGE;
                  end
               end else begin
                  byte_count_in = count_next;
               end
            end
            PH_IMAGE: begin
               running_crc_in       = crc_step;
               byte_count_in        = count_next;
               result_valid         = 1'b1;
               result.write_valid   = 1'b1;
               result.write_address = hdr_ff[HDR_ENTRY] + cur_count;
               result.write_data    = req_chan.data_byte;
               // Last image byte: report the verdict.
               if (count_next == hdr_ff[HDR_SIZE]) begin
                  phase_in             = PH_DONE;
                  result.verdict_valid = 1'b1;
                  result.status        = ((~crc_step) == hdr_ff[HDR_CRC]) ?
                                         STATUS_OK : STATUS_BAD_CRC;
                  result.entry_address = hdr_ff[HDR_ENTRY];
                  result.computed_crc  = ~crc_step;
               end
            end
            default: begin
               // Finished: bytes are dropped until a restart.
            end
         endcase
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         byte_count_ff    <= 32'd0;
         running_crc_ff   <= ALL_ONES;
         magic_cfg_ff     <= RESET_MAGIC;
         max_bytes_cfg_ff <= RESET_MAX_BYTES;
      end else begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         running_crc_ff <= running_crc_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_EXPECTED_MAGIC:  magic_cfg_ff     <= csr_write_data;
               CSR_MAX_IMAGE_BYTES: max_bytes_cfg_ff <= csr_write_data;
               default: begin
                  // Unmapped index: write is dropped.
               end
            endcase
         end
      end
   end

   // Header bytes are always written before they are used.
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   // Output register with skid entry.
   bic_rsp_skid u_rsp_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (result_valid),
      .push_data  (result),
      .push_ready (push_ready),
      .rsp_chan   (rsp_chan)
   );

   // The header counter never runs past the header.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> byte_count_ff < 32'(HEADER_BYTES))
      else $error("header byte count out of range");

   // In the image phase the offset stays below the image size.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IMAGE |-> byte_count_ff < hdr_ff[HDR_SIZE])
      else $error("image offset reached the image size without a verdict");

   // Every verdict leaves the checker finished.
   assert property (@(posedge clock) disable iff (reset)
      result_valid && result.verdict_valid |=> phase_ff == PH_DONE)
      else $error("verdict given but checker not finished");

endmodule
